FILE: rtl/neck_servo_safety_envelope_unit_assert.svh
// Assertion macros shared by the neck servo safety envelope checker
`ifndef NECK_SERVO_SAFETY_ENVELOPE_UNIT_ASSERT_SVH
`define NECK_SERVO_SAFETY_ENVELOPE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define NSSE_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define NSSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/nsse_pkg.sv
// Shared types, register codes, limits and helpers for the neck servo safety envelope
`default_nettype none

package nsse_pkg;

  // Field widths
  localparam int unsigned TGT_W   = 16;
  localparam int unsigned GAIN_W  = 13;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 80;
  localparam int unsigned OUT_USER_W = 4;

  typedef logic [TGT_W-1:0]         tgt_t;
  typedef logic signed [TGT_W-1:0]  off_t;
  typedef logic signed [GAIN_W-1:0] gain_t;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAN_MIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_CENTER   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_MAX      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_MIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_MAX    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_MIN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_MAX    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTER_GAIN = 3'd7;

  // Register reset values
  localparam tgt_t  RST_PAN_MIN      = 16'd4000;
  localparam tgt_t  RST_PAN_CENTER   = 16'd6000;
  localparam tgt_t  RST_PAN_MAX      = 16'd8000;
  localparam tgt_t  RST_LOWER_MIN    = 16'd4375;
  localparam tgt_t  RST_LOWER_MAX    = 16'd7675;
  localparam tgt_t  RST_UPPER_MIN    = 16'd4300;
  localparam tgt_t  RST_UPPER_MAX    = 16'd7790;
  localparam gain_t RST_COUNTER_GAIN = -13'sd256;

  // Envelope and leveling constants
  localparam tgt_t FULL_PAN_LOWER_THRESHOLD = 16'd5300;
  localparam tgt_t UPRIGHT_LOWER            = 16'd6000;
  localparam off_t RESTRICTED_PAN_OFFSET    = 16'sd1000;
  localparam off_t FORWARD_MIN_OFFSET       = -16'sd500;
  localparam off_t FORWARD_MAX_OFFSET       = 16'sd70;

  // Configuration register file contents
  typedef struct packed {
    tgt_t  pan_min;
    tgt_t  pan_center;
    tgt_t  pan_max;
    tgt_t  lower_min;
    tgt_t  lower_max;
    tgt_t  upper_min;
    tgt_t  upper_max;
    gain_t counter_gain;
  } cfg_t;

  // Lower tilt, envelope and pan results
  typedef struct packed {
    tgt_t pan;
    tgt_t lower;
    logic pan_clamped;
    logic lower_clamped;
    off_t env_lo;
    off_t env_hi;
  } pan_res_t;

  // Upper tilt results
  typedef struct packed {
    tgt_t upper;
    logic upper_clamped;
    logic leveled;
  } up_res_t;

  // Clamp testing the low limit first, then the high limit
  function automatic tgt_t clamp_u16(input tgt_t v, input tgt_t lo, input tgt_t hi);
    tgt_t r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Saturate an 18-bit signed value to 16 bits
  function automatic off_t sat16(input logic signed [17:0] v);
    off_t r;
    if (v > 18'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/nsse_pan_env.sv
// Lower tilt clamp, pan envelope selection and pan clamp
`default_nettype none

module nsse_pan_env (
  input  wire nsse_pkg::cfg_t     cfg,
  input  wire nsse_pkg::tgt_t     pan_request,
  input  wire nsse_pkg::tgt_t     lower_request,
  output nsse_pkg::pan_res_t      res
);

  nsse_pkg::tgt_t      lower;
  logic signed [16:0]  neg_span;
  logic signed [16:0]  pos_span;
  logic signed [16:0]  full_span;
  logic signed [17:0]  full_ext;
  nsse_pkg::off_t      env_lo;
  nsse_pkg::off_t      env_hi;
  nsse_pkg::tgt_t      hard;
  logic signed [16:0]  off_raw;
  logic signed [16:0]  off_hi;
  logic signed [16:0]  off_cl;
  logic signed [17:0]  pan_sum;
  nsse_pkg::tgt_t      pan_fin;
  nsse_pkg::tgt_t      pan;

  // Clamp lower tilt unless it is off
  assign lower = (lower_request == '0) ? '0 :
                 nsse_pkg::clamp_u16(lower_request, cfg.lower_min, cfg.lower_max);

  // Full symmetric span around center
  assign neg_span  = $signed({1'b0, cfg.pan_center} - {1'b0, cfg.pan_min});
  assign pos_span  = $signed({1'b0, cfg.pan_max} - {1'b0, cfg.pan_center});
  assign full_span = (neg_span < pos_span) ? neg_span : pos_span;
  assign full_ext  = {full_span[16], full_span};

  // Pick the envelope window
  always_comb begin
    priority if (lower_request == '0) begin
      env_lo = nsse_pkg::FORWARD_MIN_OFFSET;
      env_hi = nsse_pkg::FORWARD_MAX_OFFSET;
    end else if (lower < nsse_pkg::FULL_PAN_LOWER_THRESHOLD) begin
      env_lo = -nsse_pkg::RESTRICTED_PAN_OFFSET;
      env_hi = nsse_pkg::RESTRICTED_PAN_OFFSET;
    end else begin
      env_lo = nsse_pkg::sat16(-full_ext);
      env_hi = nsse_pkg::sat16(full_ext);
    end
  end

  // Hard clamp, then clamp the offset: high bound first, low bound last
  assign hard    = nsse_pkg::clamp_u16(pan_request, cfg.pan_min, cfg.pan_max);
  assign off_raw = $signed({1'b0, hard} - {1'b0, cfg.pan_center});
  assign off_hi  = (off_raw > 17'(env_hi)) ? 17'(env_hi) : off_raw;
  assign off_cl  = (off_hi < 17'(env_lo)) ? 17'(env_lo) : off_hi;
  assign pan_sum = $signed({2'b00, cfg.pan_center}) + 18'(off_cl);

  // Bring pan back inside the hard limits
  always_comb begin
    if (pan_sum < $signed({2'b00, cfg.pan_min})) begin
      pan_fin = cfg.pan_min;
    end else if (pan_sum > $signed({2'b00, cfg.pan_max})) begin
      pan_fin = cfg.pan_max;
    end else begin
      pan_fin = pan_sum[15:0];
    end
  end

  assign pan = (pan_request == '0) ? '0 : pan_fin;

  assign res.pan           = pan;
  assign res.lower         = lower;
  assign res.pan_clamped   = (pan != pan_request);
  assign res.lower_clamped = (lower != lower_request);
  assign res.env_lo        = env_lo;
  assign res.env_hi        = env_hi;

endmodule

`default_nettype wire

FILE: rtl/nsse_level.sv
// Upper tilt leveling: gain times lower offset, rounding and clamp
`default_nettype none

module nsse_level (
  input  wire nsse_pkg::cfg_t  cfg,
  input  wire nsse_pkg::tgt_t  upper_request,
  input  wire nsse_pkg::tgt_t  lower,
  output nsse_pkg::up_res_t    res
);

  logic signed [16:0] diff;
  logic signed [29:0] prod;
  logic               apply;
  logic signed [29:0] prod_a;
  logic signed [31:0] scaled;
  logic signed [31:0] umin_s;
  logic signed [31:0] umax_s;
  logic [31:0]        mag;
  logic [31:0]        mag_rnd;
  logic signed [24:0] rmag;
  logic signed [24:0] rounded;
  nsse_pkg::tgt_t     upper_cl;
  logic               ureq_on;

  // Leveling product in 1/256 target units
  assign diff   = $signed({1'b0, lower} - {1'b0, nsse_pkg::UPRIGHT_LOWER});
  assign prod   = cfg.counter_gain * diff;
  assign apply  = (cfg.counter_gain != '0) && (lower != '0);
  assign prod_a = apply ? prod : '0;

  assign scaled = $signed({8'd0, upper_request, 8'd0}) + {{2{prod_a[29]}}, prod_a};
  assign umin_s = $signed({8'd0, cfg.upper_min, 8'd0});
  assign umax_s = $signed({8'd0, cfg.upper_max, 8'd0});

  // Round half away from zero on the magnitude
  assign mag     = scaled[31] ? 32'(-scaled) : 32'(scaled);
  assign mag_rnd = mag + 32'd128;
  assign rmag    = $signed({1'b0, mag_rnd[31:8]});
  assign rounded = scaled[31] ? -rmag : rmag;

  // Clamp to upper limits
  always_comb begin
    if (rounded < $signed({9'd0, cfg.upper_min})) begin
      upper_cl = cfg.upper_min;
    end else if (rounded > $signed({9'd0, cfg.upper_max})) begin
      upper_cl = cfg.upper_max;
    end else begin
      upper_cl = rounded[15:0];
    end
  end

  assign ureq_on = (upper_request != '0);

  assign res.upper         = ureq_on ? upper_cl : '0;
  assign res.upper_clamped = ureq_on && ((scaled < umin_s) || (scaled > umax_s));
  assign res.leveled       = ureq_on && (prod_a != '0);

endmodule

`default_nettype wire

FILE: rtl/neck_servo_safety_envelope_unit.sv
// Neck servo safety envelope: register file, input register, datapath and result register
//
// Takes servo command words (pan, lower tilt, upper tilt; 0 = off) and returns one safe word
// each through the input register and then the result register, one word per cycle while
// out_tready is high: the lower tilt clamp feeds both the pan envelope and the 13x17 leveling
// multiplier in one combinational pass between the input and result registers. out_tdata
// holds pan_out, lower_out, upper_out, envelope_low and envelope_high from the lowest bit
// up; out_tuser holds the four clamp and leveling flags. The user must write registers
// through the cfg port only while no command is in flight; the block does not enforce it.
`default_nettype none

module neck_servo_safety_envelope_unit (
  input  wire                                    clk,
  input  wire                                    rst_n,
  // Command input
  input  wire                                    in_tvalid,
  output logic                                   in_tready,
  // [15:0] pan_request, [31:16] lower_request, [47:32] upper_request
  input  wire  [nsse_pkg::IN_DATA_W-1:0]         in_tdata,
  // Result output
  output logic                                   out_tvalid,
  input  wire                                    out_tready,
  // [15:0] pan_out, [31:16] lower_out, [47:32] upper_out,
  // [63:48] envelope_low, [79:64] envelope_high
  output logic [nsse_pkg::OUT_DATA_W-1:0]        out_tdata,
  // [0] pan_was_clamped, [1] lower_was_clamped, [2] upper_was_clamped,
  // [3] upper_was_leveled
  output logic [nsse_pkg::OUT_USER_W-1:0]        out_tuser,
  // Configuration writes
  input  wire                                    cfg_valid,
  output logic                                   cfg_ready,
  input  wire  [nsse_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire  [nsse_pkg::CFG_DATA_W-1:0]        cfg_data
);

  nsse_pkg::cfg_t    cfg_r;
  logic              s1_valid_r;
  logic [nsse_pkg::IN_DATA_W-1:0] s1_data_r;
  logic              out_valid_r;
  logic [nsse_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [nsse_pkg::OUT_USER_W-1:0] out_user_r;
  logic              out_free;
  nsse_pkg::pan_res_t pan_res;
  nsse_pkg::up_res_t  up_res;

  // Register file: always ready, unknown indexes dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pan_min      <= nsse_pkg::RST_PAN_MIN;
      cfg_r.pan_center   <= nsse_pkg::RST_PAN_CENTER;
      cfg_r.pan_max      <= nsse_pkg::RST_PAN_MAX;
      cfg_r.lower_min    <= nsse_pkg::RST_LOWER_MIN;
      cfg_r.lower_max    <= nsse_pkg::RST_LOWER_MAX;
      cfg_r.upper_min    <= nsse_pkg::RST_UPPER_MIN;
      cfg_r.upper_max    <= nsse_pkg::RST_UPPER_MAX;
      cfg_r.counter_gain <= nsse_pkg::RST_COUNTER_GAIN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        nsse_pkg::REG_PAN_MIN:      cfg_r.pan_min      <= cfg_data;
        nsse_pkg::REG_PAN_CENTER:   cfg_r.pan_center   <= cfg_data;
        nsse_pkg::REG_PAN_MAX:      cfg_r.pan_max      <= cfg_data;
        nsse_pkg::REG_LOWER_MIN:    cfg_r.lower_min    <= cfg_data;
        nsse_pkg::REG_LOWER_MAX:    cfg_r.lower_max    <= cfg_data;
        nsse_pkg::REG_UPPER_MIN:    cfg_r.upper_min    <= cfg_data;
        nsse_pkg::REG_UPPER_MAX:    cfg_r.upper_max    <= cfg_data;
        nsse_pkg::REG_COUNTER_GAIN: cfg_r.counter_gain <= cfg_data[nsse_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow: advance whenever the next stage is empty or draining
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_data_r <= in_tdata;
    end
  end

  // Datapath
  nsse_pan_env u_pan_env (
    .cfg           (cfg_r),
    .pan_request   (s1_data_r[15:0]),
    .lower_request (s1_data_r[31:16]),
    .res           (pan_res)
  );

  nsse_level u_level (
    .cfg           (cfg_r),
    .upper_request (s1_data_r[47:32]),
    .lower         (pan_res.lower),
    .res           (up_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) begin
      out_data_r <= {pan_res.env_hi, pan_res.env_lo, up_res.upper,
                     pan_res.lower, pan_res.pan};
      out_user_r <= {up_res.leveled, up_res.upper_clamped,
                     pan_res.lower_clamped, pan_res.pan_clamped};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire

FILE: rtl/nsse_checker.sv
// Port-level checker for the neck servo safety envelope, bound to the top level
`default_nettype none

`include "neck_servo_safety_envelope_unit_assert.svh"

module nsse_checker (
  input wire                               clk,
  input wire                               rst_n,
  input wire                               in_tvalid,
  input wire                               in_tready,
  input wire                               out_tvalid,
  input wire                               out_tready,
  input wire [nsse_pkg::OUT_DATA_W-1:0]    out_tdata,
  input wire [nsse_pkg::OUT_USER_W-1:0]    out_tuser,
  input wire                               cfg_valid,
  input wire                               cfg_ready
);

  logic       in_acc;
  logic       out_acc;
  logic       cfg_acc;
  logic [1:0] occ_r;
  logic [1:0] occ_nxt;
  logic       occ_ok;
  logic       idle_ok;
  logic       lvl_on;
  logic       lower_on;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign cfg_acc = cfg_valid && cfg_ready;

  // Track words in flight between the two sides
  always_comb begin
    occ_nxt = occ_r;
    if (in_acc && !out_acc) begin
      occ_nxt = occ_r + 2'd1;
    end else if (out_acc && !in_acc) begin
      occ_nxt = occ_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 2'd0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  assign occ_ok   = (occ_r != 2'd3) && ((occ_r != 2'd0) || !out_tvalid);
  assign idle_ok  = (occ_r == 2'd0) && !in_acc;
  assign lvl_on   = out_tvalid && out_tuser[3];
  assign lower_on = (out_tdata[31:16] != 16'd0);

  // A stalled result stays offered
  `NSSE_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")

  // A draining output always lets a new command in
  `NSSE_ASSERT_IMPLY(a_back_to_back, out_tready, in_tready, "input blocked while output drains")

  // No more than the two pipeline registers hold words, and none appear from nowhere
  `NSSE_ASSERT_IMPLY(a_occupancy, 1'b1, occ_ok, "word count mismatch")

  // Leveling only happens with the lower tilt on
  `NSSE_ASSERT_IMPLY(a_level_lower, lvl_on, lower_on, "leveled with lower off")

  // Register writes land only with nothing in flight
  `NSSE_ASSERT_IMPLY(a_cfg_idle, cfg_acc, idle_ok, "register write with words in flight")

endmodule

bind neck_servo_safety_envelope_unit nsse_checker u_nsse_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);

`default_nettype wire
